[design/ssc_pkg.sv]
// Shared types and constants for the counted Shell sort block.
// No dependencies; imported by ssc_ram and shell_sort_counted.
package ssc_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic [COUNT_W-1:0]       count_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SETUP,
        ST_PASS,
        ST_ITEM,
        ST_HOLD,
        ST_CMP,
        ST_WB,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

endpackage

[design/shell_sort_counted.sv]
// Shell sort (Hibbard gaps) with saturating move and compare counters.
// Loading: one item per cycle while s_tready is high; last item starts the sort.
// Sort: ITEM, HOLD, CMP per compare, WB per element; all passes on one store port.
// Output: n results, each read then held until taken; s_tready low until the last.
// Reset (rst_n low, async): empty set, counters and drop flag cleared; store not cleared.
module shell_sort_counted #(
    parameter int MAX_ITEMS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side: tdata = value[31:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    // master side: tdata = sorted_value[31:0], move_count[47:32], compare_count[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic        m_tlast,
    // tuser = overflow
    output logic        m_tuser
);
    import ssc_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int KW = $clog2(CW);

    // control state
    state_t         state_reg,    state_next;
    logic [CW-1:0]  count_reg,    count_next;
    logic [KW-1:0]  k_reg,        k_next;
    logic [CW-1:0]  i_reg,        i_next;
    logic [CW-1:0]  hole_reg,     hole_next;
    logic           shifted_reg,  shifted_next;
    count_t         moves_reg,    moves_next;
    count_t         compares_reg, compares_next;
    logic           dropped_reg,  dropped_next;
    logic           ovalid_reg,   ovalid_next;
    logic           olast_reg,    olast_next;
    // payload
    word_t          held_reg,     held_next;
    word_t          oval_reg,     oval_next;

    // store port
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    word_t          ram_wdata;
    logic [AW-1:0]  ram_raddr;
    word_t          ram_rdata;

    logic [CW-1:0]  gap;
    logic [KW-1:0]  lg;
    logic [CW-1:0]  hole_dn;
    logic [CW-1:0]  hole_dn2;

    ssc_ram #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // current gap 2^k - 1
    assign gap      = (CW'(1) << k_reg) - CW'(1);
    assign hole_dn  = hole_reg - gap;
    // next probe below the new hole
    assign hole_dn2 = hole_dn - gap;

    // floor(log2 n)
    always_comb
    begin
        lg = '0;
        for (int b = 0; b < CW; b++)
        begin
            if (count_reg[b])
            begin
                lg = KW'(b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            k_reg        <= '0;
            i_reg        <= '0;
            hole_reg     <= '0;
            shifted_reg  <= 1'b0;
            moves_reg    <= '0;
            compares_reg <= '0;
            dropped_reg  <= 1'b0;
            ovalid_reg   <= 1'b0;
            olast_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            k_reg        <= k_next;
            i_reg        <= i_next;
            hole_reg     <= hole_next;
            shifted_reg  <= shifted_next;
            moves_reg    <= moves_next;
            compares_reg <= compares_next;
            dropped_reg  <= dropped_next;
            ovalid_reg   <= ovalid_next;
            olast_reg    <= olast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        oval_reg <= oval_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        hole_next     = hole_reg;
        shifted_next  = shifted_reg;
        moves_next    = moves_reg;
        compares_next = compares_reg;
        dropped_next  = dropped_reg;
        ovalid_next   = ovalid_reg;
        olast_next    = olast_reg;
        held_next     = held_reg;
        oval_next     = oval_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[AW-1:0];
        ram_wdata     = word_t'(s_tdata);
        ram_raddr     = i_reg[AW-1:0];
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end

            ST_SETUP:
            begin
                // first k = floor(log2 n) - 2; short sets go straight to gap 1
                if (int'(lg) >= 4)
                begin
                    k_next = lg - KW'(2);
                end
                else
                begin
                    k_next = KW'(1);
                end
                state_next = ST_PASS;
            end

            ST_PASS:
            begin
                i_next     = gap;
                state_next = ST_ITEM;
            end

            ST_ITEM:
            begin
                if (i_reg >= count_reg)
                begin
                    if (k_reg == KW'(1))
                    begin
                        i_next     = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        k_next     = k_reg - KW'(1);
                        state_next = ST_PASS;
                    end
                end
                else
                begin
                    // take the element out
                    hole_next    = i_reg;
                    shifted_next = 1'b0;
                    if (moves_reg != COUNT_MAX)
                    begin
                        moves_next = moves_reg + count_t'(1);
                    end
                    state_next = ST_HOLD;
                end
            end

            ST_HOLD:
            begin
                held_next  = ram_rdata;
                ram_raddr  = hole_dn[AW-1:0];
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (held_reg < ram_rdata)
                begin
                    // shift neighbor up by the gap
                    ram_we       = 1'b1;
                    ram_waddr    = hole_reg[AW-1:0];
                    ram_wdata    = ram_rdata;
                    hole_next    = hole_dn;
                    shifted_next = 1'b1;
                    if (moves_reg != COUNT_MAX)
                    begin
                        moves_next = moves_reg + count_t'(1);
                    end
                    if (compares_reg != COUNT_MAX)
                    begin
                        compares_next = compares_reg + count_t'(1);
                    end
                    ram_raddr = hole_dn2[AW-1:0];
                    if (hole_dn < gap)
                    begin
                        state_next = ST_WB;
                    end
                end
                else
                begin
                    state_next = ST_WB;
                end
            end

            ST_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = hole_reg[AW-1:0];
                ram_wdata = held_reg;
                if (moves_reg != COUNT_MAX)
                begin
                    moves_next = moves_reg + count_t'(1);
                end
                // a lone failing compare counts only when nothing moved
                if (!shifted_reg && compares_reg != COUNT_MAX)
                begin
                    compares_next = compares_reg + count_t'(1);
                end
                i_next     = i_reg + CW'(1);
                state_next = ST_ITEM;
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                oval_next   = ram_rdata;
                olast_next  = (i_reg == count_reg - CW'(1));
                ovalid_next = 1'b1;
                state_next  = ST_EMIT_WAIT;
            end

            ST_EMIT_WAIT:
            begin
                if (m_tready)
                begin
                    ovalid_next = 1'b0;
                    if (olast_reg)
                    begin
                        count_next    = '0;
                        moves_next    = '0;
                        compares_next = '0;
                        dropped_next  = 1'b0;
                        state_next    = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // counts and the drop flag hold still for the whole emission
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {compares_reg, moves_reg, oval_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = dropped_reg;

`ifndef SYNTHESIS
    // never loading and emitting at once
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("load and emit overlap");

    // a set being sorted or emitted is never empty
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (count_reg != '0))
        else $error("sorting an empty set");

    // the final result hands control back to loading
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && moves_reg == '0))
        else $error("no return to load after final result");
`endif

endmodule

[design/ssc_ram.sv]
// Element store: single write port, single read port with registered data.
// Depends on ssc_pkg for the word type.
module ssc_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  ssc_pkg::word_t      wdata,
    input  logic [AW-1:0]       raddr,
    output ssc_pkg::word_t      rdata
);
    import ssc_pkg::*;

    word_t mem [DEPTH];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
